[rtl/core/ems_page_mapper_macros.svh]
// assertion macros used by the checker file
`ifndef EMS_PAGE_MAPPER_MACROS_SVH
`define EMS_PAGE_MAPPER_MACROS_SVH

// same-cycle implication, reset masks the check
`define EMSPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("emspm check failed");

// next-cycle implication, reset masks the check
`define EMSPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("emspm check failed");

`endif

[rtl/core/emspm_pkg.sv]
// ----------------------------------------------------------------------------
// emspm_pkg
// types and constants of the expanded-memory page mapper
// ----------------------------------------------------------------------------
`default_nettype none

package emspm_pkg;

   localparam int unsigned NUM_WIN = 4;

   typedef enum logic [1:0] {
      OP_IO_RD  = 2'd0,
      OP_IO_WR  = 2'd1,
      OP_MEM_RD = 2'd2,
      OP_MEM_WR = 2'd3
   } op_type;

   typedef enum logic {
      CSR_RAM_SIZE_KB  = 1'b0,
      CSR_MODEL_VARIANT = 1'b1
   } csr_index_type;

   localparam logic [13:0] PORT_PAGE     = 14'h0208;
   localparam logic [13:0] PORT_CONTROL  = 14'h0209;
   localparam logic [11:0] RAM_BASE_KB   = 12'd640;
   localparam logic [11:0] RESET_RAM_KB  = 12'd640;
   localparam logic [7:0]  PAGE_RESET    = 8'h7F;
   localparam logic [3:0]  BASE_RESET    = 4'd7;
   localparam logic [7:0]  READ_NONE     = 8'hFF;
   localparam logic [11:0] MODEL0_ADJ_KB = 12'd64;
   localparam logic [11:0] MODEL1_ADJ_KB = 12'd320;
   localparam logic [20:0] MODEL0_BASE   = 21'h70000;
   localparam logic [20:0] MODEL1_BASE   = 21'h30000;

   localparam logic [NUM_WIN-1:0][7:0] CONTROL_RESET = {8'h00, 8'h80, 8'h80, 8'h80};

   typedef struct packed {
      op_type      op;
      logic [15:0] io_port;
      logic [19:0] mem_addr;
      logic [7:0]  wdata;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        window_hit;
      logic [20:0] ram_addr;
      logic        ram_in_range;
      logic        ram_write_enable;
   } rsp_type;

   typedef struct packed {
      logic          valid;
      csr_index_type index;
      logic [11:0]   data;
   } csr_cmd_type;

   typedef struct packed {
      logic        page_we;
      logic        control_we;
      logic [1:0]  win;
      logic [7:0]  data;
   } reg_wr_type;

   typedef struct packed {
      logic [11:0]              ram_size_kb;
      logic                     model_variant;
      logic [NUM_WIN-1:0][7:0]  pages;
      logic [NUM_WIN-1:0][7:0]  controls;
      logic [3:0]               base_index;
   } reg_view_type;

endpackage

`default_nettype wire

[rtl/core/emspm_if.sv]
// ----------------------------------------------------------------------------
// emspm interfaces
// request, response and register-write channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface emspm_req_if;
   logic                 valid;
   logic                 ready;
   emspm_pkg::op_type    op;
   logic [15:0]          io_port;
   logic [19:0]          mem_addr;
   logic [7:0]           wdata;

   modport source (output valid, output op, output io_port, output mem_addr,
                   output wdata, input ready);
   modport sink   (input valid, input op, input io_port, input mem_addr,
                   input wdata, output ready);
endinterface

interface emspm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        window_hit;
   logic [20:0] ram_addr;
   logic        ram_in_range;
   logic        ram_write_enable;

   modport source (output valid, output read_data, output window_hit, output ram_addr,
                   output ram_in_range, output ram_write_enable, input ready);
   modport sink   (input valid, input read_data, input window_hit, input ram_addr,
                   input ram_in_range, input ram_write_enable, output ready);
endinterface

interface emspm_csr_if;
   logic                      valid;
   logic                      ready;
   emspm_pkg::csr_index_type  index;
   logic [11:0]               data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/emspm_regs.sv]
// ----------------------------------------------------------------------------
// emspm_regs
// configuration, page, control and base index registers
// ----------------------------------------------------------------------------
`default_nettype none

module emspm_regs (
   input  wire                      clock,
   input  wire                      reset,
   input  emspm_pkg::csr_cmd_type   csr_cmd,
   input  emspm_pkg::reg_wr_type    reg_wr,
   output emspm_pkg::reg_view_type  view
);
   import emspm_pkg::*;

   logic [11:0]               ram_size_kb_ff, ram_size_kb_in;
   logic                      model_variant_ff, model_variant_in;
   logic [NUM_WIN-1:0][7:0]   pages_ff, pages_in;
   logic [NUM_WIN-1:0][7:0]   controls_ff, controls_in;
   logic [3:0]                base_index_ff, base_index_in;

   always_comb begin
      ram_size_kb_in   = ram_size_kb_ff;
      model_variant_in = model_variant_ff;
      if (csr_cmd.valid) begin
         case (csr_cmd.index)
            CSR_RAM_SIZE_KB:   ram_size_kb_in   = csr_cmd.data;
            CSR_MODEL_VARIANT: model_variant_in = csr_cmd.data[0];
            default:           ram_size_kb_in   = ram_size_kb_ff;
         endcase
      end

      pages_in    = pages_ff;
      controls_in = controls_ff;
      if (reg_wr.page_we) begin
         pages_in[reg_wr.win] = reg_wr.data;
      end
      if (reg_wr.control_we) begin
         controls_in[reg_wr.win] = reg_wr.data;
      end

      base_index_in = base_index_ff;
      if (reg_wr.control_we) begin
         for (int i = 0; i < NUM_WIN; i++) begin
            base_index_in[i] = controls_in[i][7];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_size_kb_ff   <= RESET_RAM_KB;
         model_variant_ff <= 1'b0;
         pages_ff         <= {NUM_WIN{PAGE_RESET}};
         controls_ff      <= CONTROL_RESET;
         base_index_ff    <= BASE_RESET;
      end else begin
         ram_size_kb_ff   <= ram_size_kb_in;
         model_variant_ff <= model_variant_in;
         pages_ff         <= pages_in;
         controls_ff      <= controls_in;
         base_index_ff    <= base_index_in;
      end
   end

   assign view.ram_size_kb   = ram_size_kb_ff;
   assign view.model_variant = model_variant_ff;
   assign view.pages         = pages_ff;
   assign view.controls      = controls_ff;
   assign view.base_index    = base_index_ff;

endmodule

`default_nettype wire

[rtl/core/emspm_xlate.sv]
// ----------------------------------------------------------------------------
// emspm_xlate
// port decode, window match and EMS address translation for one request
// ----------------------------------------------------------------------------
`default_nettype none

module emspm_xlate (
   input  emspm_pkg::req_type       req,
   input  emspm_pkg::reg_view_type  view,
   output emspm_pkg::rsp_type       rsp,
   output emspm_pkg::reg_wr_type    reg_wr
);
   import emspm_pkg::*;

   logic        is_io;
   logic        present;
   logic        port_page;
   logic        port_control;
   logic [1:0]  io_win;
   logic [1:0]  mem_win;
   logic [7:0]  page;
   logic [3:0]  sel;
   logic        hit;
   logic [11:0] adj0;
   logic [11:0] adj1;
   logic [20:0] ems_base;
   logic [20:0] raddr;
   logic [21:0] limit;
   logic        in_range;

   assign is_io        = (req.op == OP_IO_RD) || (req.op == OP_IO_WR);
   assign present      = view.ram_size_kb > RAM_BASE_KB;
   assign io_win       = req.io_port[15:14];
   assign port_page    = present && (req.io_port[13:0] == PORT_PAGE);
   assign port_control = present && (req.io_port[13:0] == PORT_CONTROL);

   // window i sits at C0000h + 16K*(i + ((base + 4 - i) & 0Ch))
   assign mem_win = req.mem_addr[15:14];
   assign page    = view.pages[mem_win];
   assign sel     = view.base_index + 4'd4 - {2'b00, mem_win};
   assign hit     = page[7] && (req.mem_addr[19:18] == 2'b11)
                    && (req.mem_addr[17:16] == sel[3:2]);

   assign adj0 = view.ram_size_kb + MODEL0_ADJ_KB;
   assign adj1 = view.ram_size_kb + MODEL1_ADJ_KB;
   assign ems_base = view.model_variant ? (MODEL1_BASE + {2'b00, adj1[8:0], 10'b0})
                                        : (MODEL0_BASE + {3'b000, adj0[7:0], 10'b0});
   assign raddr = ems_base + {2'b00, page[6], page[3:0], 14'b0}
                  + {7'b0, req.mem_addr[13:0]};
   assign limit    = {view.ram_size_kb, 10'b0};
   assign in_range = {1'b0, raddr} < limit;

   always_comb begin
      rsp = '0;
      if (is_io) begin
         rsp.read_data = READ_NONE;
         if (req.op == OP_IO_RD) begin
            if (port_page) begin
               rsp.read_data = view.pages[io_win];
            end else if (port_control) begin
               rsp.read_data = view.controls[io_win];
            end
         end
      end else if (hit) begin
         rsp.window_hit       = 1'b1;
         rsp.ram_addr         = raddr;
         rsp.ram_in_range     = in_range;
         rsp.ram_write_enable = in_range && (req.op == OP_MEM_WR);
      end
   end

   assign reg_wr.page_we    = (req.op == OP_IO_WR) && port_page;
   assign reg_wr.control_we = (req.op == OP_IO_WR) && port_control;
   assign reg_wr.win        = io_win;
   assign reg_wr.data       = req.wdata;

endmodule

`default_nettype wire

[rtl/core/ems_page_mapper.sv]
// ----------------------------------------------------------------------------
// ems_page_mapper
// expanded-memory page mapper with four 16 KB windows
// ----------------------------------------------------------------------------
// Takes one request per clock while responses are not stalled and returns one
// response for each: an input register holds the request, one stage of decode
// and translation reads and updates the page and control registers, and the
// response register holds the result until the sink takes it. Page and control
// writes take effect in request order, so a read right behind a write sees it.
// Throughput is set by that single translation stage; a stalled response
// holds the pipe without losing requests. Register writes are taken at once.
`default_nettype none

module ems_page_mapper (
   input  wire          clock,
   input  wire          reset,
   emspm_req_if.sink    req_bus,
   emspm_rsp_if.source  rsp_bus,
   emspm_csr_if.sink    csr_bus
);
   import emspm_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   req_type       s1_req_ff, s1_req_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   rsp_type       xl_rsp;
   reg_wr_type    reg_wr;
   reg_wr_type    xl_wr;
   reg_view_type  view;
   csr_cmd_type   csr_cmd;
   logic          advance;
   logic          req_fire;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_fire = req_bus.valid && req_bus.ready;

   assign csr_bus.ready = 1'b1;
   assign csr_cmd.valid = csr_bus.valid;
   assign csr_cmd.index = csr_bus.index;
   assign csr_cmd.data  = csr_bus.data;

   emspm_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_cmd (csr_cmd),
      .reg_wr  (reg_wr),
      .view    (view)
   );

   emspm_xlate u_xlate (
      .req    (s1_req_ff),
      .view   (view),
      .rsp    (xl_rsp),
      .reg_wr (xl_wr)
   );

   always_comb begin
      reg_wr = xl_wr;
      reg_wr.page_we    = xl_wr.page_we && advance;
      reg_wr.control_we = xl_wr.control_we && advance;

      s1_req_in          = s1_req_ff;
      s1_req_in.op       = req_bus.op;
      s1_req_in.io_port  = req_bus.io_port;
      s1_req_in.mem_addr = req_bus.mem_addr;
      s1_req_in.wdata    = req_bus.wdata;
      if (!req_fire) begin
         s1_req_in = s1_req_ff;
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      rsp_in = advance ? xl_rsp : rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.read_data        = rsp_ff.read_data;
   assign rsp_bus.window_hit       = rsp_ff.window_hit;
   assign rsp_bus.ram_addr         = rsp_ff.ram_addr;
   assign rsp_bus.ram_in_range     = rsp_ff.ram_in_range;
   assign rsp_bus.ram_write_enable = rsp_ff.ram_write_enable;

endmodule

`default_nettype wire

[rtl/core/emspm_checker.sv]
// ----------------------------------------------------------------------------
// emspm_checker
// response port checks for the page mapper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ems_page_mapper_macros.svh"

module emspm_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [7:0]  read_data,
   input wire        window_hit,
   input wire [20:0] ram_addr,
   input wire        ram_in_range,
   input wire        ram_write_enable
);

   `EMSPM_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `EMSPM_ASSERT_NOW(a_miss_clean, clock, reset, rsp_valid && !window_hit, ram_addr == 21'd0 && !ram_in_range && !ram_write_enable)
   `EMSPM_ASSERT_NOW(a_we_needs_range, clock, reset, rsp_valid && ram_write_enable, window_hit && ram_in_range)
   `EMSPM_ASSERT_NOW(a_hit_no_read, clock, reset, rsp_valid && window_hit, read_data == 8'd0)

endmodule

bind ems_page_mapper emspm_checker u_emspm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .read_data        (rsp_bus.read_data),
   .window_hit       (rsp_bus.window_hit),
   .ram_addr         (rsp_bus.ram_addr),
   .ram_in_range     (rsp_bus.ram_in_range),
   .ram_write_enable (rsp_bus.ram_write_enable)
);

`default_nettype wire

[tb/sv/tb_ems_page_mapper.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ems_page_mapper
// self-checking bench for the expanded-memory page mapper: directed and
// random i/o and memory requests under several ram sizes and both models,
// every response checked against a tracked copy of the page, control and
// base index registers
// ----------------------------------------------------------------------------

module tb_ems_page_mapper;

   import emspm_pkg::*;

   class ems_map_tracker;
      logic [11:0] ram_kb;
      logic        model_sel;
      logic [7:0]  pages [NUM_WIN];
      logic [7:0]  controls [NUM_WIN];
      logic [3:0]  base_idx;
      rsp_type     due_rsp [$];
      int          errors;

      function new();
         ram_kb    = RESET_RAM_KB;
         model_sel = 1'b0;
         for (int i = 0; i < NUM_WIN; i++) begin
            pages[i]    = PAGE_RESET;
            controls[i] = CONTROL_RESET[i];
         end
         base_idx = BASE_RESET;
         errors   = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [11:0] value);
         if (idx == CSR_RAM_SIZE_KB) begin
            ram_kb = value;
         end else begin
            model_sel = value[0];
         end
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         logic [1:0]  w;
         logic [7:0]  pg;
         int unsigned kb, wi, bi, pgi, start, ems_base, raddr;
         e  = '0;
         kb = 32'(ram_kb);
         if (r.op == OP_IO_RD || r.op == OP_IO_WR) begin
            w = r.io_port[15:14];
            e.read_data = READ_NONE;
            if (kb > RAM_BASE_KB && r.io_port[13:0] == PORT_PAGE) begin
               if (r.op == OP_IO_WR) begin
                  pages[w] = r.wdata;
               end else begin
                  e.read_data = pages[w];
               end
            end else if (kb > RAM_BASE_KB && r.io_port[13:0] == PORT_CONTROL) begin
               if (r.op == OP_IO_WR) begin
                  controls[w] = r.wdata;
                  for (int i = 0; i < NUM_WIN; i++) base_idx[i] = controls[i][7];
               end else begin
                  e.read_data = controls[w];
               end
            end
         end else begin
            w     = r.mem_addr[15:14];
            wi    = 32'(w);
            bi    = 32'(base_idx);
            pg    = pages[w];
            pgi   = 32'(pg);
            start = 32'hC0000 + ((wi + ((bi + 4 - wi) & 32'hC)) << 14);
            if (pg[7] && r.mem_addr >= start && r.mem_addr < start + 32'h4000) begin
               if (model_sel) begin
                  ems_base = MODEL1_BASE + (((kb + MODEL1_ADJ_KB) & 511) << 10);
               end else begin
                  ems_base = MODEL0_BASE + (((kb + MODEL0_ADJ_KB) & 255) << 10);
               end
               raddr = (ems_base + ((pgi & 32'h0F) << 14) + ((pgi & 32'h40) << 12)
                        + (r.mem_addr & 32'h3FFF)) & 32'h1FFFFF;
               e.window_hit       = 1'b1;
               e.ram_addr         = raddr[20:0];
               e.ram_in_range     = raddr < (kb << 10);
               e.ram_write_enable = (r.op == OP_MEM_WR) && e.ram_in_range;
            end
         end
         due_rsp.push_back(e);
      endfunction

      function void compare(string field, logic [31:0] exp, logic [31:0] act);
         if (act !== exp) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, field, exp, act);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (due_rsp.size() == 0) begin
            $display("%0t unexpected response: expected none actual %h", $time, got);
            errors++;
         end else begin
            e = due_rsp.pop_front();
            compare("read_data", 32'(e.read_data), 32'(got.read_data));
            compare("window_hit", 32'(e.window_hit), 32'(got.window_hit));
            compare("ram_addr", 32'(e.ram_addr), 32'(got.ram_addr));
            compare("ram_in_range", 32'(e.ram_in_range), 32'(got.ram_in_range));
            compare("ram_write_enable", 32'(e.ram_write_enable),
                    32'(got.ram_write_enable));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;

   ems_map_tracker sb = new;

   emspm_req_if req_bus ();
   emspm_rsp_if rsp_bus ();
   emspm_csr_if csr_bus ();

   ems_page_mapper dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #4 clock = ~clock;

   function automatic req_type make_req(op_type op, logic [15:0] port, logic [19:0] addr,
                                        logic [7:0] data);
      req_type r;
      r.op       = op;
      r.io_port  = port;
      r.mem_addr = addr;
      r.wdata    = data;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick, w, sel;
      r = make_req(OP_IO_RD, 16'($urandom_range(0, 16'hFFFF)),
                   20'($urandom_range(0, 20'hFFFFF)), 8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.op = (pick < 25) ? OP_IO_WR : OP_IO_RD;
         if ($urandom_range(0, 9) != 0) begin
            r.io_port[13:0] = $urandom_range(0, 1) ? PORT_PAGE : PORT_CONTROL;
         end
         if (r.io_port[13:0] == PORT_PAGE && $urandom_range(0, 3) != 0) r.wdata[7] = 1'b1;
      end else begin
         r.op = $urandom_range(0, 1) ? OP_MEM_RD : OP_MEM_WR;
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            // aim at the window that the current base index places
            w   = 32'(r.mem_addr[15:14]);
            sel = (sb.base_idx + 4 - w) & 32'hC;
            r.mem_addr = 20'(20'hC0000 + ((w + sel) << 14) + r.mem_addr[13:0]);
         end else if (pick < 9) begin
            r.mem_addr[19:18] = 2'b11;
         end
      end
      return r;
   endfunction

   task automatic send_request(req_type r);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.op       <= r.op;
      req_bus.io_port  <= r.io_port;
      req_bus.mem_addr <= r.mem_addr;
      req_bus.wdata    <= r.wdata;
      req_bus.valid    <= 1'b1;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_request(r);
      if ($urandom_range(0, 39) == 0) req_calm = ~req_calm;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.due_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_settings(logic [11:0] kb, logic variant);
      logic [11:0] d;
      csr_bus.index <= CSR_RAM_SIZE_KB;
      csr_bus.data  <= kb;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      sb.write_register(CSR_RAM_SIZE_KB, kb);
      d = 12'($urandom_range(0, 4095));
      d[0] = variant;
      csr_bus.index <= CSR_MODEL_VARIANT;
      csr_bus.data  <= d;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      sb.write_register(CSR_MODEL_VARIANT, d);
      csr_bus.valid <= 1'b0;
   endtask

   // response side
   initial begin
      int unsigned gap;
      rsp_type     got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         got.read_data        = rsp_bus.read_data;
         got.window_hit       = rsp_bus.window_hit;
         got.ram_addr         = rsp_bus.ram_addr;
         got.ram_in_range     = rsp_bus.ram_in_range;
         got.ram_write_enable = rsp_bus.ram_write_enable;
         sb.check_response(got);
         if ($urandom_range(0, 39) == 0) rsp_calm = ~rsp_calm;
      end
   end

   initial begin
      logic [11:0] kb_list [8];
      logic        var_list [8];
      kb_list  = '{12'd641, 12'd768, 12'd2048, 12'd1024, 12'd0, 12'd1536, 12'd2048, 12'd700};
      var_list = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      kb_list[7] = 12'($urandom_range(641, 2048));
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.op       <= OP_IO_RD;
      req_bus.io_port  <= '0;
      req_bus.mem_addr <= '0;
      req_bus.wdata    <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_RAM_SIZE_KB;
      csr_bus.data     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ems absent at the reset size
      send_request(make_req(OP_IO_RD, 16'h0208, 20'h00000, 8'h00));
      send_request(make_req(OP_IO_WR, 16'h0208, 20'h00000, 8'h80));
      send_request(make_req(OP_IO_RD, 16'h0208, 20'h00000, 8'h00));
      send_request(make_req(OP_MEM_RD, 16'h0000, 20'hC0000, 8'h00));
      send_request(make_req(OP_MEM_WR, 16'hFFFF, 20'hFFFFF, 8'hFF));

      wait_idle();
      write_settings(12'd2048, 1'b1);
      send_request(make_req(OP_IO_RD, 16'h0208, 20'h00000, 8'h00));
      send_request(make_req(OP_IO_RD, 16'hC209, 20'h00000, 8'h00));
      send_request(make_req(OP_IO_WR, 16'h0208, 20'h00000, 8'h80));
      send_request(make_req(OP_IO_WR, 16'h4208, 20'h00000, 8'hCF));
      send_request(make_req(OP_IO_WR, 16'h8208, 20'h00000, 8'hFF));
      send_request(make_req(OP_IO_WR, 16'hC208, 20'h00000, 8'hB5));
      send_request(make_req(OP_IO_RD, 16'hC208, 20'h00000, 8'h00));
      send_request(make_req(OP_IO_WR, 16'hC209, 20'h00000, 8'h80));
      send_request(make_req(OP_IO_RD, 16'h0209, 20'h00000, 8'h00));
      send_request(make_req(OP_IO_RD, 16'h0210, 20'h00000, 8'h00));
      send_request(make_req(OP_IO_RD, 16'h1208, 20'h00000, 8'h00));
      send_request(make_req(OP_IO_WR, 16'hFFFF, 20'h00000, 8'hAA));
      send_request(make_req(OP_MEM_RD, 16'h0000, 20'hC0000, 8'h00));
      send_request(make_req(OP_MEM_WR, 16'h0000, 20'hC3FFF, 8'h5A));
      send_request(make_req(OP_MEM_RD, 16'h0000, 20'hC4000, 8'h00));
      send_request(make_req(OP_MEM_WR, 16'h0000, 20'hCFFFF, 8'hA5));
      send_request(make_req(OP_MEM_RD, 16'h0000, 20'h00000, 8'h00));
      send_request(make_req(OP_IO_WR, 16'h0209, 20'h00000, 8'h00));
      send_request(make_req(OP_MEM_RD, 16'h0000, 20'hFC000, 8'h00));
      send_request(make_req(OP_MEM_WR, 16'h0000, 20'hFFFFF, 8'hFF));

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_settings(kb_list[p], var_list[p]);
         repeat (105) begin
            if ($urandom_range(0, 49) == 0) wait_idle();
            send_request(random_request());
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      sb.errors += sb.due_rsp.size();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/emspm_pkg.sv
rtl/core/emspm_if.sv
rtl/core/emspm_regs.sv
rtl/core/emspm_xlate.sv
rtl/core/ems_page_mapper.sv
rtl/core/emspm_checker.sv
tb/sv/tb_ems_page_mapper.sv
